[rtl/pbf_pkg.sv]
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared widths, datapath control codes and the control word for the
// parallel bandpass formant filter.
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 64;
    localparam int YH_W      = 20;
    localparam int XD_W      = SAMPLE_W + 1;
    localparam int MUL_A_W   = YH_W;
    localparam int PROD_W    = MUL_A_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int COEF_FRAC = 14;
    localparam int SCALE_W   = 15;
    localparam int OUT_SHIFT = 29;

    localparam logic signed [SCALE_W-1:0] SCALE_Q15 = 15'sd10813;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    localparam logic [1:0] TOT_HOLD = 2'd0;
    localparam logic [1:0] TOT_CLR  = 2'd1;
    localparam logic [1:0] TOT_ADD  = 2'd2;

    typedef struct packed {
        logic [1:0] acc_op;
        logic       y_load;
        logic [1:0] tot_op;
        logic       scale_load;
    } dp_ctrl_t;

endpackage

[rtl/pbf_ram.sv]
// ----------------------------------------------------------------------------
// pbf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/pbf_dp.sv]
// ----------------------------------------------------------------------------
// pbf_dp
// Shared multiplier with product register, band accumulator, band output
// rounding and saturation, gain sum, output scaling and saturation.
// ----------------------------------------------------------------------------
module pbf_dp
    import pbf_pkg::*;
#(
    parameter int NUM_BANDS = 3
) (
    input  logic                       aclk,
    input  dp_ctrl_t                   ctrl,
    input  logic signed [MUL_A_W-1:0]  mul_a,
    input  logic signed [COEF_W-1:0]   mul_b,
    output logic signed [YH_W-1:0]     y_out,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int TOT_W = PROD_W + $clog2(NUM_BANDS + 1);
    localparam int SC_W  = TOT_W + SCALE_W;
    localparam int YQ_W  = ACC_W - COEF_FRAC;
    localparam int RQ_W  = SC_W - OUT_SHIFT;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** (COEF_FRAC - 1));
    localparam logic signed [SC_W-1:0]  SC_HALF  = SC_W'(2 ** (OUT_SHIFT - 1));
    localparam logic signed [YQ_W-1:0]  YQ_MAX   = YQ_W'(2 ** (YH_W - 1) - 1);
    localparam logic signed [YQ_W-1:0]  YQ_MIN   = YQ_W'(-(2 ** (YH_W - 1)));
    localparam logic signed [RQ_W-1:0]  RQ_MAX   = RQ_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [RQ_W-1:0]  RQ_MIN   = RQ_W'(-(2 ** (SAMPLE_W - 1)));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [YH_W-1:0]   y_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic signed [SC_W-1:0]   scaled_reg;

    logic signed [ACC_W-1:0]  prod_acc;
    logic signed [TOT_W-1:0]  prod_tot;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [YQ_W-1:0]   yq;
    logic signed [YH_W-1:0]   y_sat;
    logic signed [SC_W-1:0]   sc_rnd;
    logic signed [RQ_W-1:0]   rq;

    assign prod_acc = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign prod_tot = {{(TOT_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    assign acc_rnd = acc_reg + ACC_HALF;
    assign yq      = acc_rnd[ACC_W-1:COEF_FRAC];

    always_comb begin
        if (yq > YQ_MAX) begin
            y_sat = YQ_MAX[YH_W-1:0];
        end else if (yq < YQ_MIN) begin
            y_sat = YQ_MIN[YH_W-1:0];
        end else begin
            y_sat = yq[YH_W-1:0];
        end
    end

    assign sc_rnd = scaled_reg + SC_HALF;
    assign rq     = sc_rnd[SC_W-1:OUT_SHIFT];

    always_comb begin
        if (rq > RQ_MAX) begin
            result = RQ_MAX[SAMPLE_W-1:0];
        end else if (rq < RQ_MIN) begin
            result = RQ_MIN[SAMPLE_W-1:0];
        end else begin
            result = rq[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= prod_acc;
            ACC_SUB:  acc_reg <= acc_reg - prod_acc;
            default:  acc_reg <= acc_reg;
        endcase

        if (ctrl.y_load) begin
            y_reg <= y_sat;
        end

        case (ctrl.tot_op)
            TOT_CLR: total_reg <= '0;
            TOT_ADD: total_reg <= total_reg + prod_tot;
            default: total_reg <= total_reg;
        endcase

        if (ctrl.scale_load) begin
            scaled_reg <= total_reg * SCALE_Q15;
        end
    end

    assign y_out = y_reg;

endmodule

[rtl/parallel_bandpass_formant_filter.sv]
// One word is in process at a time; the single shared multiplier forms four
// products per band in sequence.
// Reset: synchronous, active low; coefficients and all filter history read
// as zero after reset (per-entry valid bits), no clearing pass.
// ----------------------------------------------------------------------------
// parallel_bandpass_formant_filter
// Three-band parallel bandpass biquad bank; history in two RAMs, one shared
// multiply-accumulate sequenced per band, gain sum scaled by 0.33.
// ----------------------------------------------------------------------------
module parallel_bandpass_formant_filter
    import pbf_pkg::*;
#(
    parameter int NUM_BANDS    = 3,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [15:0] sample_in
    input  logic [0:0]             s_tuser,   // [0] channel

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [15:0] sample_out
    output logic [0:0]             m_tuser,   // [0] channel_out

    input  logic                   cfg_wr_en,
    input  logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]       cfg_wr_data
);

    localparam int BAND_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int Y_DEPTH = NUM_BANDS * NUM_CHANNELS;
    localparam int Y_AW    = (Y_DEPTH > 1) ? $clog2(Y_DEPTH) : 1;
    localparam int XM_W    = 2 * SAMPLE_W;
    localparam int YM_W    = 2 * YH_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_P0   = 4'd2;
    localparam logic [3:0] ST_P1   = 4'd3;
    localparam logic [3:0] ST_P2   = 4'd4;
    localparam logic [3:0] ST_P3   = 4'd5;
    localparam logic [3:0] ST_P4   = 4'd6;
    localparam logic [3:0] ST_P5   = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_SCL  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]                 state_reg, state_next;
    logic [BAND_W-1:0]          band_reg;
    logic [BAND_W-1:0]          band_rd;
    logic                       band_first;
    logic                       band_last;
    logic signed [SAMPLE_W-1:0] x_reg, x1_reg, x2_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [CH_W-1:0]            ch_in;
    logic signed [YH_W-1:0]     y1_reg, y2_reg;
    logic [CFG_W-1:0]           coef_reg [NUM_BANDS];
    logic [NUM_CHANNELS-1:0]    xvalid_reg;
    logic [Y_DEPTH-1:0]         yvalid_reg;
    logic                       xrd_valid_reg, yrd_valid_reg;
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_tdata_reg;
    logic                       m_tuser_reg;

    logic                       x_wr_en, x_rd_en;
    logic [XM_W-1:0]            x_wr_data, x_rd_data;
    logic                       y_wr_en, y_rd_en;
    logic [Y_AW-1:0]            y_wr_addr, y_rd_addr;
    logic [YM_W-1:0]            y_wr_data, y_rd_data;

    logic signed [SAMPLE_W-1:0] x_mem_h1, x_mem_h2, x2_cur;
    logic signed [YH_W-1:0]     y_mem_h1, y_mem_h2;
    logic signed [XD_W-1:0]     xd;
    logic [CFG_W-1:0]           coef_cur;
    logic signed [COEF_W-1:0]   c_b0, c_a1, c_a2, c_gain;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [YH_W-1:0]     y_out;
    logic signed [SAMPLE_W-1:0] result;
    dp_ctrl_t                   dp_ctrl;
    logic                       accept;
    logic                       out_load;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign band_first = (band_reg == '0);
    assign band_last  = (band_reg == BAND_W'(NUM_BANDS - 1));
    assign ch_in      = (NUM_CHANNELS > 1) ? CH_W'(s_tuser) : '0;

    // Coefficients
    assign coef_cur = coef_reg[band_reg];
    assign c_b0     = coef_cur[15:0];
    assign c_a1     = coef_cur[31:16];
    assign c_a2     = coef_cur[47:32];
    assign c_gain   = coef_cur[63:48];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (int'(cfg_wr_index) < NUM_BANDS)) begin
            coef_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    // History memories: input history per channel, output history per band/channel
    assign x_rd_en   = (state_reg == ST_RD);
    assign x_wr_en   = (state_reg == ST_P1) && band_first;
    assign x_wr_data = {x1_reg, x_reg};

    assign band_rd   = (state_reg == ST_P5) ? band_reg + 1'b1 : band_reg;
    assign y_rd_en   = (state_reg == ST_RD) || ((state_reg == ST_P5) && !band_last);
    assign y_rd_addr = Y_AW'(int'(band_rd) * NUM_CHANNELS + int'(ch_reg));
    assign y_wr_en   = (state_reg == ST_P5);
    assign y_wr_addr = Y_AW'(int'(band_reg) * NUM_CHANNELS + int'(ch_reg));
    assign y_wr_data = {y1_reg, y_out};

    pbf_ram #(
        .WIDTH (XM_W),
        .DEPTH (NUM_CHANNELS)
    ) u_xhist (
        .aclk    (aclk),
        .wr_en   (x_wr_en),
        .wr_addr (ch_reg),
        .wr_data (x_wr_data),
        .rd_en   (x_rd_en),
        .rd_addr (ch_reg),
        .rd_data (x_rd_data)
    );

    pbf_ram #(
        .WIDTH (YM_W),
        .DEPTH (Y_DEPTH)
    ) u_yhist (
        .aclk    (aclk),
        .wr_en   (y_wr_en),
        .wr_addr (y_wr_addr),
        .wr_data (y_wr_data),
        .rd_en   (y_rd_en),
        .rd_addr (y_rd_addr),
        .rd_data (y_rd_data)
    );

    assign x_mem_h1 = xrd_valid_reg ? x_rd_data[SAMPLE_W-1:0] : '0;
    assign x_mem_h2 = xrd_valid_reg ? x_rd_data[XM_W-1:SAMPLE_W] : '0;
    assign y_mem_h1 = yrd_valid_reg ? y_rd_data[YH_W-1:0] : '0;
    assign y_mem_h2 = yrd_valid_reg ? y_rd_data[YM_W-1:YH_W] : '0;
    assign x2_cur   = band_first ? x_mem_h2 : x2_reg;
    assign xd       = {x_reg[SAMPLE_W-1], x_reg} - {x2_cur[SAMPLE_W-1], x2_cur};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xvalid_reg    <= '0;
            yvalid_reg    <= '0;
            xrd_valid_reg <= 1'b0;
            yrd_valid_reg <= 1'b0;
        end else begin
            if (x_wr_en) begin
                xvalid_reg[ch_reg] <= 1'b1;
            end
            if (y_wr_en) begin
                yvalid_reg[y_wr_addr] <= 1'b1;
            end
            if (x_rd_en) begin
                xrd_valid_reg <= xvalid_reg[ch_reg];
            end
            if (y_rd_en) begin
                yrd_valid_reg <= yvalid_reg[y_rd_addr];
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD;
            ST_RD:   state_next = ST_P0;
            ST_P0:   state_next = ST_P1;
            ST_P1:   state_next = ST_P2;
            ST_P2:   state_next = ST_P3;
            ST_P3:   state_next = ST_P4;
            ST_P4:   state_next = ST_P5;
            ST_P5:   state_next = band_last ? ST_FIN : ST_P0;
            ST_FIN:  state_next = ST_SCL;
            ST_SCL:  state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            band_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                band_reg <= '0;
            end else if ((state_reg == ST_P5) && !band_last) begin
                band_reg <= band_rd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg  <= s_tdata;
            ch_reg <= ch_in;
        end
        if (state_reg == ST_P0) begin
            y1_reg <= y_mem_h1;
            y2_reg <= y_mem_h2;
            if (band_first) begin
                x1_reg <= x_mem_h1;
                x2_reg <= x_mem_h2;
            end
        end
    end

    // Multiplier operands and datapath control
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        dp_ctrl = '{acc_op: ACC_HOLD, y_load: 1'b0, tot_op: TOT_HOLD, scale_load: 1'b0};
        case (state_reg)
            ST_P0: begin
                mul_a          = {{(MUL_A_W - XD_W){xd[XD_W-1]}}, xd};
                mul_b          = c_b0;
                dp_ctrl.tot_op = band_first ? TOT_CLR : TOT_ADD;
            end
            ST_P1: begin
                mul_a          = y1_reg;
                mul_b          = c_a1;
                dp_ctrl.acc_op = ACC_LOAD;
            end
            ST_P2: begin
                mul_a          = y2_reg;
                mul_b          = c_a2;
                dp_ctrl.acc_op = ACC_SUB;
            end
            ST_P3: dp_ctrl.acc_op = ACC_SUB;
            ST_P4: dp_ctrl.y_load = 1'b1;
            ST_P5: begin
                mul_a = y_out;
                mul_b = c_gain;
            end
            ST_FIN: dp_ctrl.tot_op = TOT_ADD;
            ST_SCL: dp_ctrl.scale_load = 1'b1;
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pbf_dp #(
        .NUM_BANDS (NUM_BANDS)
    ) u_dp (
        .aclk   (aclk),
        .ctrl   (dp_ctrl),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .y_out  (y_out),
        .result (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= result;
            m_tuser_reg <= ch_reg[0];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Checks
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside output state");

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        !(y_wr_en && y_rd_en && (y_wr_addr == y_rd_addr)))
        else $error("output history read and write hit the same entry");

    a_band_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(band_reg) < NUM_BANDS)
        else $error("band counter out of range");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_RD) && (band_reg == '0))
        else $error("accepted word did not start the band sequence");

endmodule

[tb/tb_parallel_bandpass_formant_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parallel_bandpass_formant_filter
// Stream-level check of the three-band formant filter bank. A cycle-free
// software copy of the filter predicts every output word from the sample
// words the block accepts. In the random and drain phases, words go in with
// random gaps while the output side stalls at random. Coefficient sets are
// swapped between phases: reset values, directed extremes, stable random
// bands, raw random patterns and saturating settings.
// ----------------------------------------------------------------------------
module tb_parallel_bandpass_formant_filter;
    import pbf_pkg::*;

    localparam int     NBANDS         = 3;
    localparam int     NCHAN          = 2;
    localparam longint GAIN_SUM_SCALE = 10813;
    localparam longint Y_MAX          = 524287;
    localparam longint Y_MIN          = -524288;
    localparam int     SETTLE_CYCLES  = 30;
    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     PHASE_WORDS    = 135;

    localparam logic [1:0] REG_BAND0 = 2'd0;
    localparam logic [1:0] REG_BAND1 = 2'd1;
    localparam logic [1:0] REG_BAND2 = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic [63:0] COEF_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] COEF_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] COEF_MIN  = 64'h8000_8000_8000_8000;
    localparam logic [63:0] COEF_MAX  = 64'h7FFF_7FFF_7FFF_7FFF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [0:0]         chan;
    } formant_out_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [CFG_W-1:0] cfg_wr_data;

    logic [63:0]        band_coef [NBANDS];
    logic signed [15:0] x_hist1 [NCHAN];
    logic signed [15:0] x_hist2 [NCHAN];
    logic signed [19:0] y_hist1 [NBANDS*NCHAN];
    logic signed [19:0] y_hist2 [NBANDS*NCHAN];

    formant_out_t pending_outputs[$];
    int errors = 0;
    int cycles = 0;
    int stall_left = 0;
    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;

    always #5 aclk = ~aclk;

    parallel_bandpass_formant_filter #(
        .NUM_BANDS    (NBANDS),
        .NUM_CHANNELS (NCHAN)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic formant_out_t filter_sample(input logic signed [15:0] x,
                                                   input logic [0:0] ch);
        longint b0, a1, a2, gain, y1, y2, acc, y, total, xd;
        int b, k;
        formant_out_t r;
        xd = longint'(x) - longint'(x_hist2[ch]);
        total = 0;
        for (b = 0; b < NBANDS; b++) begin
            b0   = $signed(band_coef[b][15:0]);
            a1   = $signed(band_coef[b][31:16]);
            a2   = $signed(band_coef[b][47:32]);
            gain = $signed(band_coef[b][63:48]);
            k    = b * NCHAN + int'(ch);
            y1   = y_hist1[k];
            y2   = y_hist2[k];
            acc  = b0 * xd - a1 * y1 - a2 * y2;
            y    = clamp((acc + 64'sd8192) >>> 14, Y_MIN, Y_MAX);
            y_hist2[k] = y1[19:0];
            y_hist1[k] = y[19:0];
            total += y * gain;
        end
        x_hist2[ch] = x_hist1[ch];
        x_hist1[ch] = x;
        total = clamp((total * GAIN_SUM_SCALE + 64'sd268435456) >>> 29, -32768, 32767);
        r.sample = total[15:0];
        r.chan   = ch;
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom);
        if (r < 85) return 16'($urandom_range(0, 512) - 256);
        case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // |a2| < 1 and |a1| < 1 + a2 keep the poles inside the unit circle
    function automatic logic [63:0] stable_band();
        int a1, a2, b0, gain;
        a2   = $urandom_range(2048, 16000);
        a1   = $urandom_range(0, 2 * (16384 + a2) - 2) - (16384 + a2 - 1);
        b0   = $urandom_range(0, 16384) - 8192;
        gain = $urandom_range(0, 65535) - 32768;
        return {gain[15:0], a2[15:0], a1[15:0], b0[15:0]};
    endfunction

    function automatic logic [63:0] extreme_band();
        case ($urandom_range(0, 3))
            0: return COEF_ZERO;
            1: return COEF_ONES;
            2: return COEF_MIN;
            default: return COEF_MAX;
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (rx_stalls_on && $urandom_range(0, 99) < 30) stall_left = idle_len();
        end
    end

    always @(posedge aclk) begin
        formant_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected word: sample_out %0d channel_out %0d",
                       $signed(m_tdata), m_tuser);
                errors++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample, $signed(m_tdata));
                    errors++;
                end
                if (m_tuser !== want.chan) begin
                    $error("channel_out: expected %0d, got %0d", want.chan, m_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic send_sample(input logic [15:0] x, input logic [0:0] ch);
        int gap;
        s_tdata  = x;
        s_tuser  = ch;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_outputs.push_back(filter_sample(x, ch));
        @(negedge aclk);
        gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom);
            s_tuser  = 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_outputs.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_coeffs(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_index = idx;
        cfg_wr_data  = val;
        cfg_wr_en    = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (int'(idx) < NBANDS) band_coef[idx] = val;
    endtask

    task automatic write_all_bands(input logic [63:0] c0, input logic [63:0] c1,
                                   input logic [63:0] c2);
        write_coeffs(REG_BAND0, c0);
        write_coeffs(REG_BAND1, c1);
        write_coeffs(REG_BAND2, c2);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h1234, 1'b0);
        wait_idle();
    endtask

    task automatic test_directed_extremes();
        int i;
        // unit passband on band 0, b0 = -2.0 with maximal feedback on band 1
        write_all_bands(64'h7FFF_0000_0000_4000, 64'h8000_7FFF_8000_8000, COEF_ONES);
        write_coeffs(REG_SPARE, COEF_MAX);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        for (i = 0; i < 10; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF, 1'b0);
        wait_idle();
        write_all_bands(COEF_MIN, COEF_MAX, COEF_MIN);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int phase, i;
        logic [63:0] c [NBANDS];
        for (phase = 0; phase < 10; phase++) begin
            wait_idle();
            for (i = 0; i < NBANDS; i++) begin
                case (phase % 4)
                    0: c[i] = stable_band();
                    1: c[i] = {$urandom, $urandom};
                    2: c[i] = extreme_band();
                    default: c[i] = ($urandom_range(0, 2) == i) ? COEF_ZERO : stable_band();
                endcase
            end
            write_all_bands(c[0], c[1], c[2]);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            for (i = 0; i < PHASE_WORDS; i++) begin
                send_sample(rand_sample(), 1'($urandom));
                if ($urandom_range(0, 99) == 0) wait_idle();
            end
        end
    endtask

    task automatic test_pause_drain();
        int i;
        wait_idle();
        write_all_bands(stable_band(), stable_band(), stable_band());
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        for (i = 0; i < 60; i++) begin
            send_sample(rand_sample(), 1'($urandom));
            if (i % 10 == 9) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        int i;
        for (i = 0; i < NBANDS; i++) band_coef[i] = COEF_ZERO;
        for (i = 0; i < NCHAN; i++) begin
            x_hist1[i] = '0;
            x_hist2[i] = '0;
        end
        for (i = 0; i < NBANDS * NCHAN; i++) begin
            y_hist1[i] = '0;
            y_hist2[i] = '0;
        end
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_BAND0;
        cfg_wr_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_directed_extremes();
        test_random_phases();
        test_pause_drain();

        wait_idle();
        if (errors == 0 && pending_outputs.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
